// ===== rtl/ilme_pkg.sv =====
`timescale 1ns / 1ps
package ilme_pkg;

    localparam int MAX_SIDE = 64;
    localparam int COORD_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W   = COORD_W + 1;
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;

    localparam logic [1:0] CMD_RESEED    = 2'd0;
    localparam logic [1:0] CMD_RANDOMIZE = 2'd1;
    localparam logic [1:0] CMD_SWEEP     = 2'd2;
    localparam logic [1:0] CMD_READ      = 2'd3;

    localparam logic [IDX_W-1:0] CFG_SIDE  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_THR4  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_THR8  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_SEED0 = 3'd3;
    localparam logic [IDX_W-1:0] CFG_SEED1 = 3'd4;
    localparam logic [IDX_W-1:0] CFG_SEED2 = 3'd5;
    localparam logic [IDX_W-1:0] CFG_SEED3 = 3'd6;

    localparam logic [SIDE_W-1:0] SIDE_RST  = 7'd16;
    localparam logic [31:0]       THR4_RST  = 32'd2605029347;
    localparam logic [31:0]       THR8_RST  = 32'd1580030168;
    localparam logic [31:0]       SEED0_RST = 32'd123456789;
    localparam logic [31:0]       SEED1_RST = 32'd362436069;
    localparam logic [31:0]       SEED2_RST = 32'd521288629;
    localparam logic [31:0]       SEED3_RST = 32'd88675123;

    localparam logic [2:0] PHASE_LAST = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAND,
        S_SWEEP,
        S_ENERGY,
        S_RDA,
        S_RDB,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic reseed;
        logic rand_wr;
        logic site_run;
        logic sw_act;
        logic en_act;
        logic clr_site;
        logic rd_issue;
        logic rd_capture;
        logic out_load;
    } t_ctrl;

    typedef struct packed {
        logic last_site;
        logic phase_last;
    } t_stat;

endpackage

// ===== rtl/ilme_ram.sv =====
`timescale 1ns / 1ps
module ilme_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/ilme_ctrl.sv =====
`timescale 1ns / 1ps
module ilme_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_command,
    input  logic             i_stall,
    input  ilme_pkg::t_stat  i_stat,
    output logic             o_stall,
    output logic             o_valid,
    output ilme_pkg::t_ctrl  o_ctrl
);
    ilme_pkg::t_state r_state, n_state;
    logic r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ilme_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ilme_pkg::S_IDLE: begin
                if (i_valid) begin
                    unique case (i_command)
                        ilme_pkg::CMD_RESEED:    n_state = ilme_pkg::S_DONE;
                        ilme_pkg::CMD_RANDOMIZE: n_state = ilme_pkg::S_RAND;
                        ilme_pkg::CMD_SWEEP:     n_state = ilme_pkg::S_SWEEP;
                        default:                 n_state = ilme_pkg::S_RDA;
                    endcase
                end
            end
            ilme_pkg::S_RAND: begin
                if (i_stat.last_site) n_state = ilme_pkg::S_DONE;
            end
            ilme_pkg::S_SWEEP: begin
                if (i_stat.phase_last && i_stat.last_site) n_state = ilme_pkg::S_ENERGY;
            end
            ilme_pkg::S_ENERGY: begin
                if (i_stat.phase_last && i_stat.last_site) n_state = ilme_pkg::S_DONE;
            end
            ilme_pkg::S_RDA: n_state = ilme_pkg::S_RDB;
            ilme_pkg::S_RDB: n_state = ilme_pkg::S_DONE;
            ilme_pkg::S_DONE: begin
                if (!r_valid || !i_stall) n_state = ilme_pkg::S_IDLE;
            end
            default: n_state = ilme_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl  = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ilme_pkg::S_IDLE: begin
                o_stall      = 1'b0;
                o_ctrl.start = i_valid;
                o_ctrl.reseed = i_valid && (i_command == ilme_pkg::CMD_RESEED);
            end
            ilme_pkg::S_RAND: o_ctrl.rand_wr = 1'b1;
            ilme_pkg::S_SWEEP: begin
                o_ctrl.site_run = 1'b1;
                o_ctrl.sw_act   = i_stat.phase_last;
                o_ctrl.clr_site = i_stat.phase_last && i_stat.last_site;
            end
            ilme_pkg::S_ENERGY: begin
                o_ctrl.site_run = 1'b1;
                o_ctrl.en_act   = i_stat.phase_last;
            end
            ilme_pkg::S_RDA: o_ctrl.rd_issue = 1'b1;
            ilme_pkg::S_RDB: o_ctrl.rd_capture = 1'b1;
            ilme_pkg::S_DONE: o_ctrl.out_load = !r_valid || !i_stall;
            default: o_stall = 1'b1;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (r_valid && !i_stall) n_valid = 1'b0;
        if (o_ctrl.out_load) n_valid = 1'b1;
    end

    assign o_valid = r_valid;
endmodule

// ===== rtl/ilme_dp.sv =====
`timescale 1ns / 1ps
module ilme_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ilme_pkg::t_ctrl                   i_ctrl,
    input  logic [ilme_pkg::COORD_W-1:0]      i_column,
    input  logic [ilme_pkg::COORD_W-1:0]      i_row,
    input  logic                              i_cfg_we,
    input  logic [ilme_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [ilme_pkg::CFG_W-1:0]        i_cfg_data,
    output ilme_pkg::t_stat                   o_stat,
    output logic                              o_spin_up,
    output logic [12:0]                       o_flip_count,
    output logic signed [13:0]                o_magnetization,
    output logic signed [14:0]                o_energy
);
    localparam int CW = ilme_pkg::COORD_W;
    localparam int SW = ilme_pkg::SIDE_W;

    logic [SW-1:0] r_side;
    logic [31:0]   r_thr4, r_thr8, r_seed0, r_seed1, r_seed2, r_seed3;
    logic [31:0]   r_a, r_b, r_c, r_d;
    logic [CW-1:0] r_row, r_col, r_rd_row, r_rd_col;
    logic [2:0]    r_phase, r_up;
    logic          r_self, r_spin;
    logic [12:0]   r_flips;
    logic signed [13:0] r_mag;
    logic signed [15:0] r_twice;

    logic [SW-1:0] side_n, side_m1;
    logic [CW-1:0] last_idx, cp, cm, rp, rm;
    logic [ilme_pkg::ADDR_W-1:0] raddr, self_addr;
    logic          rd_data, mem_we, mem_wd;
    logic [31:0]   t0, t1, draw;
    logic          adv;
    logic [2:0]    u_full, k;
    logic          flip;
    logic signed [4:0] pair, term;

    always_comb begin
        if (r_side < 7'd2) side_n = 7'd2;
        else if (r_side > SW'(ilme_pkg::MAX_SIDE)) side_n = SW'(ilme_pkg::MAX_SIDE);
        else side_n = r_side;
        side_m1  = side_n - 7'd1;
        last_idx = side_m1[CW-1:0];
        cp = (r_col == last_idx) ? '0 : r_col + 1'b1;
        cm = (r_col == '0) ? last_idx : r_col - 1'b1;
        rp = (r_row == last_idx) ? '0 : r_row + 1'b1;
        rm = (r_row == '0) ? last_idx : r_row - 1'b1;
        self_addr = {r_row, r_col};
        if (i_ctrl.rd_issue) raddr = {r_rd_row, r_rd_col};
        else begin
            case (r_phase)
                3'd1:    raddr = {r_row, cp};
                3'd2:    raddr = {r_row, cm};
                3'd3:    raddr = {rm, r_col};
                3'd4:    raddr = {rp, r_col};
                default: raddr = self_addr;
            endcase
        end
    end

    always_comb begin
        t0   = r_a ^ (r_a << 11);
        t1   = t0 ^ (t0 >> 8);
        draw = r_d ^ (r_d >> 19) ^ t1;
        u_full = r_up + {2'b0, rd_data};
        k      = r_self ? u_full : 3'd4 - u_full;
        case (k)
            3'd3:    flip = draw <= r_thr4;
            3'd4:    flip = draw <= r_thr8;
            default: flip = 1'b1;
        endcase
        adv    = i_ctrl.rand_wr || (i_ctrl.sw_act && k >= 3'd2);
        mem_we = i_ctrl.rand_wr || (i_ctrl.sw_act && flip);
        mem_wd = i_ctrl.rand_wr ? draw[0] : !r_self;
        pair   = $signed({1'b0, u_full, 1'b0}) - 5'sd4;
        term   = r_self ? pair : -pair;
    end

    assign o_stat.last_site  = (r_row == last_idx) && (r_col == last_idx);
    assign o_stat.phase_last = (r_phase == ilme_pkg::PHASE_LAST);

    ilme_ram #(.WIDTH(1), .DEPTH(ilme_pkg::DEPTH)) u_lattice (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (self_addr),
        .i_wdata (mem_wd),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // configuration and generator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side  <= ilme_pkg::SIDE_RST;
            r_thr4  <= ilme_pkg::THR4_RST;
            r_thr8  <= ilme_pkg::THR8_RST;
            r_seed0 <= ilme_pkg::SEED0_RST;
            r_seed1 <= ilme_pkg::SEED1_RST;
            r_seed2 <= ilme_pkg::SEED2_RST;
            r_seed3 <= ilme_pkg::SEED3_RST;
            r_a     <= ilme_pkg::SEED0_RST;
            r_b     <= ilme_pkg::SEED1_RST;
            r_c     <= ilme_pkg::SEED2_RST;
            r_d     <= ilme_pkg::SEED3_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ilme_pkg::CFG_SIDE:  r_side  <= i_cfg_data[SW-1:0];
                    ilme_pkg::CFG_THR4:  r_thr4  <= i_cfg_data;
                    ilme_pkg::CFG_THR8:  r_thr8  <= i_cfg_data;
                    ilme_pkg::CFG_SEED0: r_seed0 <= i_cfg_data;
                    ilme_pkg::CFG_SEED1: r_seed1 <= i_cfg_data;
                    ilme_pkg::CFG_SEED2: r_seed2 <= i_cfg_data;
                    ilme_pkg::CFG_SEED3: r_seed3 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_ctrl.reseed) begin
                r_a <= r_seed0;
                r_b <= r_seed1;
                r_c <= r_seed2;
                r_d <= r_seed3;
            end else if (adv) begin
                r_a <= r_b;
                r_b <= r_c;
                r_c <= r_d;
                r_d <= draw;
            end
        end
    end

    // site walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_phase <= '0;
        end else begin
            if (i_ctrl.start || i_ctrl.clr_site) begin
                r_row <= '0;
                r_col <= '0;
            end else if (i_ctrl.rand_wr || i_ctrl.sw_act || i_ctrl.en_act) begin
                if (r_col == last_idx) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (i_ctrl.start) r_phase <= '0;
            else if (i_ctrl.site_run) begin
                r_phase <= o_stat.phase_last ? 3'd0 : r_phase + 3'd1;
            end
        end
    end

    // accumulators and results
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rd_row <= i_row;
            r_rd_col <= i_column;
            r_flips  <= '0;
            r_mag    <= '0;
            r_twice  <= '0;
            r_spin   <= 1'b0;
        end
        if (i_ctrl.site_run) begin
            case (r_phase)
                3'd1:    r_self <= rd_data;
                3'd2,
                3'd3,
                3'd4:    r_up <= r_up + {2'b0, rd_data};
                default: r_up <= '0;
            endcase
        end
        if (i_ctrl.sw_act && flip) r_flips <= r_flips + 13'd1;
        if (i_ctrl.en_act) begin
            r_mag   <= r_mag + (r_self ? 14'sd1 : -14'sd1);
            r_twice <= r_twice + {{11{term[4]}}, term};
        end
        if (i_ctrl.rd_capture) begin
            r_spin <= rd_data && ({1'b0, r_rd_row} < side_n) && ({1'b0, r_rd_col} < side_n);
        end
        if (i_ctrl.out_load) begin
            o_spin_up       <= r_spin;
            o_flip_count    <= r_flips;
            o_magnetization <= r_mag;
            o_energy        <= r_twice[15:1];
        end
    end
endmodule

// ===== rtl/ising_metropolis_lattice_engine_unit.sv =====
`timescale 1ns / 1ps
// a sweep runs a flip pass and then an energy pass over every site of the side in use;
// one site per cycle when randomizing, and six lattice memory reads per site
// for the flip pass and the energy pass
// one command in flight; a new beat is taken while the previous result waits
// synchronous active-low reset loads the register and generator defaults;
// the spin lattice holds no defined value until randomized
module ising_metropolis_lattice_engine_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_command,
    input  logic [ilme_pkg::COORD_W-1:0] i_column,
    input  logic [ilme_pkg::COORD_W-1:0] i_row,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_spin_up,
    output logic [12:0]                  o_flip_count,
    output logic signed [13:0]           o_magnetization,
    output logic signed [14:0]           o_energy,
    input  logic                         i_cfg_we,
    input  logic [ilme_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [ilme_pkg::CFG_W-1:0]   i_cfg_data
);
    ilme_pkg::t_ctrl ctrl;
    ilme_pkg::t_stat stat;

    ilme_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_stall   (i_stall),
        .i_stat    (stat),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_ctrl    (ctrl)
    );

    ilme_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_column        (i_column),
        .i_row           (i_row),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_stat          (stat),
        .o_spin_up       (o_spin_up),
        .o_flip_count    (o_flip_count),
        .o_magnetization (o_magnetization),
        .o_energy        (o_energy)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("accepted beat did not make the block busy");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctrl.rand_wr, ctrl.sw_act, ctrl.en_act, ctrl.rd_issue, ctrl.rd_capture}))
        else $error("more than one datapath action at once");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |=> o_valid)
        else $error("loaded result not presented");
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import ilme_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;

    typedef struct {
        logic               spin_up;
        logic [12:0]        flip_count;
        logic signed [13:0] magnetization;
        logic signed [14:0] energy;
    } lattice_result_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [1:0]          i_command = CMD_RESEED;
    logic [COORD_W-1:0]  i_column = '0;
    logic [COORD_W-1:0]  i_row = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_spin_up;
    logic [12:0]         o_flip_count;
    logic signed [13:0]  o_magnetization;
    logic signed [14:0]  o_energy;
    logic                i_cfg_we = 1'b0;
    logic [IDX_W-1:0]    i_cfg_index = CFG_SIDE;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    ising_metropolis_lattice_engine_unit dut (.*);

    // own copy of the engine state
    logic [6:0]  side_reg;
    logic [31:0] thr_four, thr_eight;
    logic [31:0] seed_word [4];
    logic [31:0] gen_word [4];
    logic        spins [DEPTH];
    logic        site_written [DEPTH];

    lattice_result_t pending_results [$];
    int  mismatches = 0;
    int  cycles = 0;
    int  stall_left = 0;
    bit  calm = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (calm) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        lattice_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_spin_up !== want.spin_up)
                    report_mismatch("spin_up", o_spin_up, want.spin_up);
                if (o_flip_count !== want.flip_count)
                    report_mismatch("flip_count", o_flip_count, want.flip_count);
                if (o_magnetization !== want.magnetization)
                    report_mismatch("magnetization", o_magnetization, want.magnetization);
                if (o_energy !== want.energy)
                    report_mismatch("energy", o_energy, want.energy);
            end
        end
    end

    function automatic int side_now();
        if (side_reg < 2) return 2;
        if (side_reg > MAX_SIDE) return MAX_SIDE;
        return side_reg;
    endfunction

    function automatic logic [31:0] next_draw();
        logic [31:0] t;
        t = gen_word[0];
        t ^= t << 11;
        t ^= t >> 8;
        gen_word[0] = gen_word[1];
        gen_word[1] = gen_word[2];
        gen_word[2] = gen_word[3];
        gen_word[3] ^= gen_word[3] >> 19;
        gen_word[3] ^= t;
        return gen_word[3];
    endfunction

    function automatic int spin_val(input int r, input int c);
        return spins[r * MAX_SIDE + c] ? 1 : -1;
    endfunction

    function automatic int neighbours(input int r, input int c, input int n);
        int cp, cm, rp, rm;
        cp = (c + 1 == n) ? 0 : c + 1;
        cm = (c == 0) ? n - 1 : c - 1;
        rp = (r + 1 == n) ? 0 : r + 1;
        rm = (r == 0) ? n - 1 : r - 1;
        return spin_val(r, cp) + spin_val(r, cm) + spin_val(rm, c) + spin_val(rp, c);
    endfunction

    function automatic bit lattice_ready();
        int n;
        n = side_now();
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                if (!site_written[r * MAX_SIDE + c]) return 0;
        return 1;
    endfunction

    task automatic predict_command(input logic [1:0] cmd, input int col, input int row);
        lattice_result_t res;
        int n, de, flips, mag, twice;
        logic [31:0] thr;
        bit flip;
        n = side_now();
        flips = 0;
        mag = 0;
        twice = 0;
        res.spin_up = 1'b0;
        case (cmd)
            CMD_RESEED: begin
                for (int k = 0; k < 4; k++) gen_word[k] = seed_word[k];
            end
            CMD_RANDOMIZE: begin
                for (int r = 0; r < n; r++)
                    for (int c = 0; c < n; c++) begin
                        spins[r * MAX_SIDE + c] = 1'(next_draw() & 32'd1);
                        site_written[r * MAX_SIDE + c] = 1'b1;
                    end
            end
            CMD_SWEEP: begin
                for (int r = 0; r < n; r++)
                    for (int c = 0; c < n; c++) begin
                        de = 2 * spin_val(r, c) * neighbours(r, c, n);
                        if (de < 0) begin
                            flip = 1;
                        end else begin
                            thr = (de == 0) ? 32'hFFFF_FFFF : (de == 4) ? thr_four : thr_eight;
                            flip = (next_draw() <= thr);
                        end
                        if (flip) begin
                            spins[r * MAX_SIDE + c] ^= 1'b1;
                            flips++;
                        end
                    end
                for (int r = 0; r < n; r++)
                    for (int c = 0; c < n; c++) begin
                        mag += spin_val(r, c);
                        twice += spin_val(r, c) * neighbours(r, c, n);
                    end
            end
            default: begin
                if (row < n && col < n) res.spin_up = spins[row * MAX_SIDE + col];
            end
        endcase
        res.flip_count = 13'(flips);
        res.magnetization = 14'(mag);
        res.energy = 15'(twice / 2);
        pending_results.push_back(res);
    endtask

    task automatic send_beat(input logic [1:0] cmd, input int col = 0, input int row = 0);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_command = cmd;
        i_column = COORD_W'(col);
        i_row = COORD_W'(row);
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        predict_command(cmd, col, row);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        case (idx)
            CFG_SIDE:  side_reg = value[6:0];
            CFG_THR4:  thr_four = value;
            CFG_THR8:  thr_eight = value;
            CFG_SEED0: seed_word[0] = value;
            CFG_SEED1: seed_word[1] = value;
            CFG_SEED2: seed_word[2] = value;
            CFG_SEED3: seed_word[3] = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // random command, kept away from sites never randomized
    task automatic random_command();
        int n, pick, col, row;
        n = side_now();
        pick = $urandom_range(0, 19);
        col = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
        row = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
        if (pick < 2) begin
            send_beat(CMD_RESEED, $urandom_range(0, 63), $urandom_range(0, 63));
        end else if (pick < 6 || !lattice_ready()) begin
            send_beat(CMD_RANDOMIZE, $urandom_range(0, 63), $urandom_range(0, 63));
        end else if (pick < 12) begin
            send_beat(CMD_SWEEP, $urandom_range(0, 63), $urandom_range(0, 63));
        end else if (row < n && col < n && !site_written[row * MAX_SIDE + col]) begin
            send_beat(CMD_RANDOMIZE);
        end else begin
            send_beat(CMD_READ, col, row);
        end
    endtask

    task automatic test_reset_values();
        send_beat(CMD_RANDOMIZE);
        send_beat(CMD_SWEEP);
        send_beat(CMD_READ, 0, 0);
        send_beat(CMD_READ, 15, 15);
        send_beat(CMD_READ, 63, 63);
        send_beat(CMD_READ, 16, 3);
        send_beat(CMD_RESEED);
        send_beat(CMD_RANDOMIZE);
        wait_drained();
    endtask

    task automatic test_threshold_extremes();
        set_reg(CFG_SIDE, 6);
        set_reg(CFG_THR4, 32'h0);
        set_reg(CFG_THR8, 32'h0);
        send_beat(CMD_RANDOMIZE);
        send_beat(CMD_SWEEP);
        wait_drained();
        set_reg(CFG_THR4, 32'hFFFF_FFFF);
        set_reg(CFG_THR8, 32'hFFFF_FFFF);
        send_beat(CMD_SWEEP);
        send_beat(CMD_READ, 5, 5);
        wait_drained();
    endtask

    task automatic test_side_extremes();
        set_reg(CFG_SIDE, 0);
        send_beat(CMD_RANDOMIZE);
        send_beat(CMD_SWEEP);
        send_beat(CMD_READ, 1, 1);
        send_beat(CMD_READ, 2, 0);
        wait_drained();
        set_reg(CFG_SIDE, 1);
        send_beat(CMD_SWEEP);
        wait_drained();
        set_reg(CFG_SIDE, 127);
        send_beat(CMD_RANDOMIZE);
        send_beat(CMD_SWEEP);
        send_beat(CMD_READ, 63, 0);
        send_beat(CMD_READ, 0, 63);
        wait_drained();
    endtask

    task automatic test_zero_seed();
        set_reg(CFG_SIDE, 4);
        set_reg(CFG_SEED0, 0);
        set_reg(CFG_SEED1, 0);
        set_reg(CFG_SEED2, 0);
        set_reg(CFG_SEED3, 0);
        send_beat(CMD_RESEED);
        send_beat(CMD_RANDOMIZE);
        send_beat(CMD_SWEEP);
        wait_drained();
    endtask

    task automatic test_random_phases(input int items);
        int sent, burst;
        logic [31:0] v;
        sent = 0;
        while (sent < items) begin
            wait_drained();
            if ($urandom_range(0, 9) == 0)
                set_reg(CFG_SIDE, $urandom_range(0, 127));
            else
                set_reg(CFG_SIDE, $urandom_range(2, 9));
            for (int k = 1; k <= 6; k++) begin
                if ($urandom_range(0, 1)) begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h0;
                        1: v = 32'hFFFF_FFFF;
                        default: v = $urandom;
                    endcase
                    set_reg(IDX_W'(k), v);
                end
            end
            burst = $urandom_range(5, 15);
            for (int k = 0; k < burst; k++) random_command();
            sent += burst;
        end
        wait_drained();
    endtask

    task automatic test_no_idling();
        calm = 1;
        set_reg(CFG_SIDE, 5);
        send_beat(CMD_RANDOMIZE);
        for (int k = 0; k < 20; k++) random_command();
    endtask

    initial begin
        side_reg = SIDE_RST;
        thr_four = THR4_RST;
        thr_eight = THR8_RST;
        seed_word[0] = SEED0_RST;
        seed_word[1] = SEED1_RST;
        seed_word[2] = SEED2_RST;
        seed_word[3] = SEED3_RST;
        for (int k = 0; k < 4; k++) gen_word[k] = seed_word[k];
        for (int k = 0; k < DEPTH; k++) begin
            spins[k] = 1'b0;
            site_written[k] = 1'b0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_values();
        test_threshold_extremes();
        test_side_extremes();
        test_zero_seed();
        test_random_phases(50);
        test_no_idling();
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
